FILE: hw/rtl/pmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_pkg: shared types and constants of the projection matrix generator
// Divider operand layout, operation and status codes, magnitude helper.
// ----------------------------------------------------------------------------
package pmg_pkg;

	// Divider widths: numerator magnitude and denominator magnitude
	localparam int NUM_W = 64;
	localparam int DEN_W = 33;
	localparam int N_ENTRIES = 6;

	// Operation codes
	localparam logic OP_FRUSTUM = 1'b0;
	localparam logic OP_ORTHO = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// One division: magnitudes plus the sign of the final quotient
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic neg;
	} div_op_t;

	// Magnitude of a 33-bit signed value (fits 33 bits unsigned)
	function automatic logic [DEN_W-1:0] abs33(input logic signed [DEN_W-1:0] v);
		logic [DEN_W-1:0] r;
		r = v[DEN_W-1] ? DEN_W'(-v) : DEN_W'(v);
		return r;
	endfunction

endpackage

FILE: hw/rtl/pmg_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_prep: operand preparation
// Stage 1 forms extents, sums, n*f and validity; stage 2 forms the six
// numerator/denominator magnitudes and quotient signs.
// ----------------------------------------------------------------------------
module pmg_prep #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic opcode,
	input  logic signed [31:0] left_edge,
	input  logic signed [31:0] right_edge,
	input  logic signed [31:0] bottom_edge,
	input  logic signed [31:0] top_edge,
	input  logic signed [31:0] near_dist,
	input  logic signed [31:0] far_dist,
	output pmg_pkg::div_op_t ops [pmg_pkg::N_ENTRIES],
	output logic invalid
);

	logic signed [32:0] dx, dy, dz, sx, sy, sz;
	logic bad;

	logic op_s1, bad_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1, sx_s1, sy_s1, sz_s1;
	logic signed [31:0] n_s1;
	logic signed [63:0] prod_s1;

	// Extents and sums at 33 bits
	assign dx = {right_edge[31], right_edge} - {left_edge[31], left_edge};
	assign dy = {top_edge[31], top_edge} - {bottom_edge[31], bottom_edge};
	assign dz = {far_dist[31], far_dist} - {near_dist[31], near_dist};
	assign sx = {right_edge[31], right_edge} + {left_edge[31], left_edge};
	assign sy = {top_edge[31], top_edge} + {bottom_edge[31], bottom_edge};
	assign sz = {far_dist[31], far_dist} + {near_dist[31], near_dist};

	// Volume check
	always_comb begin
		if (opcode == pmg_pkg::OP_FRUSTUM) begin
			bad = near_dist[31] || (near_dist == 32'sd0) || far_dist[31] ||
				(far_dist == 32'sd0) || dx[32] || (dx == 33'sd0) ||
				dy[32] || (dy == 33'sd0) || dz[32] || (dz == 33'sd0);
		end else begin
			bad = (dx == 33'sd0) || (dy == 33'sd0) || (dz == 33'sd0);
		end
	end

	// Stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= opcode;
			bad_s1  <= bad;
			dx_s1   <= dx;
			dy_s1   <= dy;
			dz_s1   <= dz;
			sx_s1   <= sx;
			sy_s1   <= sy;
			sz_s1   <= sz;
			n_s1    <= near_dist;
			prod_s1 <= near_dist * far_dist;
		end
	end

	// Stage 2 operands
	logic [31:0] n_mag;
	logic signed [64:0] p2;
	logic [63:0] p2_mag, n2_num, c_num, sx_num, sy_num, sz_num;
	logic [32:0] dx_mag, dy_mag, dz_mag;
	pmg_pkg::div_op_t op_c [pmg_pkg::N_ENTRIES];

	always_comb begin
		n_mag  = n_s1[31] ? 32'(-n_s1) : 32'(n_s1);
		p2     = {prod_s1, 1'b0};
		p2_mag = p2[64] ? 64'(-p2) : 64'(p2);
		n2_num = 64'(n_mag) << (FRAC_BITS + 1);
		c_num  = 64'd1 << (2 * FRAC_BITS + 1);
		sx_num = 64'(pmg_pkg::abs33(sx_s1)) << FRAC_BITS;
		sy_num = 64'(pmg_pkg::abs33(sy_s1)) << FRAC_BITS;
		sz_num = 64'(pmg_pkg::abs33(sz_s1)) << FRAC_BITS;
		dx_mag = pmg_pkg::abs33(dx_s1);
		dy_mag = pmg_pkg::abs33(dy_s1);
		dz_mag = pmg_pkg::abs33(dz_s1);
		if (op_s1 == pmg_pkg::OP_FRUSTUM) begin
			op_c[0] = '{num: n2_num, den: dx_mag, neg: n_s1[31] ^ dx_s1[32]};
			op_c[1] = '{num: n2_num, den: dy_mag, neg: n_s1[31] ^ dy_s1[32]};
			op_c[2] = '{num: sx_num, den: dx_mag, neg: sx_s1[32] ^ dx_s1[32]};
			op_c[3] = '{num: sy_num, den: dy_mag, neg: sy_s1[32] ^ dy_s1[32]};
			op_c[4] = '{num: sz_num, den: dz_mag, neg: sz_s1[32] ^ dz_s1[32]};
			op_c[5] = '{num: p2_mag, den: dz_mag, neg: !(p2[64] ^ dz_s1[32])};
		end else begin
			op_c[0] = '{num: c_num, den: dx_mag, neg: dx_s1[32]};
			op_c[1] = '{num: c_num, den: dy_mag, neg: dy_s1[32]};
			op_c[2] = '{num: sx_num, den: dx_mag, neg: !(sx_s1[32] ^ dx_s1[32])};
			op_c[3] = '{num: sy_num, den: dy_mag, neg: !(sy_s1[32] ^ dy_s1[32])};
			op_c[4] = '{num: c_num, den: dz_mag, neg: !dz_s1[32]};
			op_c[5] = '{num: sz_num, den: dz_mag, neg: !(sz_s1[32] ^ dz_s1[32])};
		end
	end

	// Stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			ops     <= op_c;
			invalid <= bad_s1;
		end
	end

endmodule

FILE: hw/rtl/pmg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_div: pipelined restoring divider
// One quotient bit per stage, NUM_W stages; unsigned magnitudes, sign rides.
// ----------------------------------------------------------------------------
module pmg_div (
	input  logic clk,
	input  logic en,
	input  pmg_pkg::div_op_t op_in,
	output logic [pmg_pkg::NUM_W-1:0] quo,
	output logic neg
);

	localparam int NW = pmg_pkg::NUM_W;
	localparam int DW = pmg_pkg::DEN_W;

	logic [DW-1:0] rem_s [NW+1];
	logic [NW-1:0] num_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic neg_s [NW+1];

	assign rem_s[0] = '0;
	assign num_s[0] = op_in.num;
	assign quo_s[0] = '0;
	assign den_s[0] = op_in.den;
	assign neg_s[0] = op_in.neg;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic [DW+1:0] diff;

		// Trial subtract of the shifted remainder
		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign diff = {1'b0, trial} - {2'b00, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
				quo_s[k+1] <= {quo_s[k][NW-2:0], !diff[DW+1]};
				num_s[k+1] <= {num_s[k][NW-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo = quo_s[NW];
	assign neg = neg_s[NW];

endmodule

FILE: hw/rtl/projection_matrix_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_matrix_generator: frustum / orthographic projection entries
// Six pipelined dividers produce m11, m22, offsets, m33 and m43 in Q format.
//
// Channel  Handshake             Payload
// input    in_valid / in_ready   opcode, left/right/bottom/top edge, near/far
// output   out_valid / out_ready scale_x/y, offset_x/y, depth_scale/offset,
//                                status
//
// 67 register stages: two operand stages, 64 divider stages (one quotient bit
// each) and the saturation/output register. The first is loaded at the
// accepting edge. One item per cycle while the output is not stalled.
// The whole pipeline advances together when the output register is empty
// or being taken; a stall freezes every stage. Reset clears valid bits only.
// ----------------------------------------------------------------------------
module projection_matrix_generator #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  logic signed [31:0] left_edge,
	input  logic signed [31:0] right_edge,
	input  logic signed [31:0] bottom_edge,
	input  logic signed [31:0] top_edge,
	input  logic signed [31:0] near_dist,
	input  logic signed [31:0] far_dist,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] scale_x,
	output logic signed [31:0] scale_y,
	output logic signed [31:0] offset_x,
	output logic signed [31:0] offset_y,
	output logic signed [31:0] depth_scale,
	output logic signed [31:0] depth_offset,
	output logic [1:0] status
);

	localparam int NW = pmg_pkg::NUM_W;
	localparam int NE = pmg_pkg::N_ENTRIES;
	localparam int DEPTH = NW + 2;

	logic en;
	pmg_pkg::div_op_t ops [NE];
	logic invalid_s2;
	logic [NW-1:0] quo [NE];
	logic neg [NE];

	// Global advance
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	pmg_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk        (clk),
		.en         (en),
		.opcode     (opcode),
		.left_edge  (left_edge),
		.right_edge (right_edge),
		.bottom_edge(bottom_edge),
		.top_edge   (top_edge),
		.near_dist  (near_dist),
		.far_dist   (far_dist),
		.ops        (ops),
		.invalid    (invalid_s2)
	);

	for (genvar e = 0; e < NE; e++) begin : g_div
		pmg_div u_div (
			.clk  (clk),
			.en   (en),
			.op_in(ops[e]),
			.quo  (quo[e]),
			.neg  (neg[e])
		);
	end

	// Valid line across prep and divider stages
	logic [DEPTH-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Invalid flag follows the divider stages
	logic [NW-1:0] inv_q;
	always_ff @(posedge clk) begin
		if (en) begin
			inv_q <= {inv_q[NW-2:0], invalid_s2};
		end
	end

	// Saturation to 32 bits
	logic [31:0] sat [NE];
	logic [NE-1:0] ovf;
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			if (neg[i]) begin
				ovf[i] = quo[i] > 64'h0000_0000_8000_0000;
				sat[i] = ovf[i] ? 32'h8000_0000 : 32'(-quo[i]);
			end else begin
				ovf[i] = quo[i] > 64'h0000_0000_7FFF_FFFF;
				sat[i] = ovf[i] ? 32'h7FFF_FFFF : quo[i][31:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (inv_q[NW-1]) begin
				scale_x      <= '0;
				scale_y      <= '0;
				offset_x     <= '0;
				offset_y     <= '0;
				depth_scale  <= '0;
				depth_offset <= '0;
				status       <= pmg_pkg::ST_INVALID;
			end else begin
				scale_x      <= sat[0];
				scale_y      <= sat[1];
				offset_x     <= sat[2];
				offset_y     <= sat[3];
				depth_scale  <= sat[4];
				depth_offset <= sat[5];
				status       <= (|ovf) ? pmg_pkg::ST_SAT : pmg_pkg::ST_OK;
			end
		end
	end

	// Checks
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pmg_pkg::ST_INVALID |->
		scale_x == 32'sd0 && offset_y == 32'sd0 && depth_offset == 32'sd0)
		else $error("invalid volume with non-zero entries");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == pmg_pkg::ST_OK || status == pmg_pkg::ST_INVALID ||
		status == pmg_pkg::ST_SAT)
		else $error("undefined status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scale_x) && $stable(status))
		else $error("stalled result changed");

endmodule
